// ===== sv/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants
// Opcodes, controller states, datapath commands and status for the mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int SLOT_BITS        = 4;
  localparam int SAMPLE_SLOTS     = 16;
  localparam int GEN_W            = 32 - SLOT_BITS - 1;
  localparam int DEF_VOICES       = 16;
  localparam int DEF_SAMPLE_WORDS = 65536;
  localparam int DIV_STEPS        = 42;
  localparam int IN_W             = 160;
  localparam int OUT_W            = 72;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 18;

  localparam logic [15:0] FADE_FLOOR  = 16'd16;
  localparam logic [15:0] RAMP_RESET  = 16'd137;
  localparam logic [17:0] ORATE_RESET = 18'd48000;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE = 1'b1;

  typedef enum logic [2:0] {
    OP_LOAD, OP_DEFINE, OP_PLAY, OP_SET_VOL, OP_SET_RATE, OP_STOP, OP_TICK, OP_SILENCE
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_HCHK, ST_MUL, ST_DIV, ST_INC_WR, ST_V_CHK, ST_V_RDA,
    ST_V_RDB, ST_V_FRM, ST_V_ACC, ST_V_NEXT, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_LATCH, DP_LOAD, DP_DEFINE, DP_PLAY_SEL, DP_HND_SEL, DP_VOL_WR,
    DP_STOP_WR, DP_SILENCE, DP_MUL, DP_DIV, DP_PLAY_WR, DP_RATE_WR, DP_TICK_INIT,
    DP_V_CHK, DP_V_RDA, DP_V_RDB, DP_V_FRM, DP_V_ACC, DP_V_NEXT, DP_RESULT
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    logic     fail;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic def_ok;
    logic play_ok;
    logic hnd_ok;
    logic v_live;
    logic div_last;
    logic last_voice;
  } dp_stat_t;

endpackage

// ===== sv/svm_ctrl.sv =====
// ----------------------------------------------------------------------------
// svm_ctrl: mixer sequencer
// Decodes each item and steps the datapath through it; owns output valid.
// ----------------------------------------------------------------------------
module svm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output svm_pkg::dp_cmd_t  cmd,
  input  svm_pkg::dp_stat_t stat
);
  import svm_pkg::*;

  state_t state_r, state_nxt;
  logic   fail_r, fail_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.step      = DP_NONE;
    cmd.fail      = fail_r;
    in_tready     = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.step  = DP_LATCH;
          fail_nxt  = 1'b0;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op)
          OP_LOAD: begin
            cmd.step  = DP_LOAD;
            state_nxt = ST_DONE;
          end
          OP_DEFINE: begin
            if (stat.def_ok) cmd.step = DP_DEFINE;
            fail_nxt  = !stat.def_ok;
            state_nxt = ST_DONE;
          end
          OP_PLAY: begin
            if (stat.play_ok) begin
              cmd.step  = DP_PLAY_SEL;
              state_nxt = ST_MUL;
            end else begin
              fail_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end
          end
          OP_SET_VOL, OP_SET_RATE, OP_STOP: begin
            cmd.step  = DP_HND_SEL;
            state_nxt = ST_HCHK;
          end
          OP_TICK: begin
            cmd.step  = DP_TICK_INIT;
            state_nxt = ST_V_CHK;
          end
          default: begin
            cmd.step  = DP_SILENCE;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_HCHK: begin
        if (!stat.hnd_ok) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          case (stat.op)
            OP_SET_VOL: begin
              cmd.step  = DP_VOL_WR;
              state_nxt = ST_DONE;
            end
            OP_STOP: begin
              cmd.step  = DP_STOP_WR;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_MUL;
          endcase
        end
      end
      ST_MUL: begin
        cmd.step  = DP_MUL;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = DP_DIV;
        if (stat.div_last) state_nxt = ST_INC_WR;
      end
      ST_INC_WR: begin
        cmd.step  = (stat.op == OP_PLAY) ? DP_PLAY_WR : DP_RATE_WR;
        state_nxt = ST_DONE;
      end
      ST_V_CHK: begin
        cmd.step  = DP_V_CHK;
        state_nxt = stat.v_live ? ST_V_RDA : ST_V_NEXT;
      end
      ST_V_RDA: begin
        cmd.step  = DP_V_RDA;
        state_nxt = ST_V_RDB;
      end
      ST_V_RDB: begin
        cmd.step  = DP_V_RDB;
        state_nxt = ST_V_FRM;
      end
      ST_V_FRM: begin
        cmd.step  = DP_V_FRM;
        state_nxt = ST_V_ACC;
      end
      ST_V_ACC: begin
        cmd.step  = DP_V_ACC;
        state_nxt = ST_V_NEXT;
      end
      ST_V_NEXT: begin
        cmd.step  = DP_V_NEXT;
        state_nxt = stat.last_voice ? ST_DONE : ST_V_CHK;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.step      = DP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== sv/svm_dp.sv =====
// ----------------------------------------------------------------------------
// svm_dp: mixer datapath
// Sample memory, sample table, voice state, increment divider and mix path.
// ----------------------------------------------------------------------------
module svm_dp #(
  parameter int VOICES       = svm_pkg::DEF_VOICES,
  parameter int SAMPLE_WORDS = svm_pkg::DEF_SAMPLE_WORDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [svm_pkg::IN_W-1:0]         in_tdata,
  input  logic                             cfg_wr_en,
  input  logic [svm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  svm_pkg::dp_cmd_t                 cmd,
  output svm_pkg::dp_stat_t                stat,
  output logic [svm_pkg::OUT_W-1:0]        out_tdata
);
  import svm_pkg::*;

  localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);   // depth is a power of two
  localparam int SW = (AW > 17) ? AW : 17;

  // configuration
  logic [15:0] ramp_r;
  logic [17:0] orate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r  <= RAMP_RESET;
      orate_r <= ORATE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RAMP_STEP:   ramp_r  <= cfg_wdata[15:0];
        CFG_OUTPUT_RATE: orate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item fields
  op_t         op_r;
  logic [3:0]  sid_r;
  logic [31:0] handle_r;
  logic [15:0] vol_r, rate_r, waddr_r, wval_r, start_r;
  logic [16:0] len_r;
  logic [17:0] srate_r;

  always_ff @(posedge clk) begin
    if (cmd.step == DP_LATCH) begin
      op_r     <= op_t'(in_tdata[2:0]);
      sid_r    <= in_tdata[6:3];
      handle_r <= in_tdata[38:7];
      vol_r    <= in_tdata[54:39];
      rate_r   <= in_tdata[70:55];
      waddr_r  <= in_tdata[86:71];
      wval_r   <= in_tdata[102:87];
      start_r  <= in_tdata[118:103];
      len_r    <= in_tdata[135:119];
      srate_r  <= in_tdata[153:136];
    end
  end

  // sample table
  logic [15:0] st_start_r [SAMPLE_SLOTS];
  logic [16:0] st_len_r   [SAMPLE_SLOTS];
  logic [17:0] st_rate_r  [SAMPLE_SLOTS];
  logic [SAMPLE_SLOTS-1:0] st_def_r;

  // voice state
  logic [VOICES-1:0] vact_r, vstop_r;
  logic [GEN_W-1:0]  vgen_r  [VOICES];
  logic [3:0]        vsmp_r  [VOICES];
  logic [39:0]       vpos_r  [VOICES];
  logic [15:0]       vnow_r  [VOICES];
  logic [15:0]       vtgt_r  [VOICES];
  logic [31:0]       vinc_r  [VOICES];
  logic [VB-1:0]     vidx_r;

  // table lookup, one address at a time
  logic [3:0]  st_idx;
  logic [15:0] st_start_rd;
  logic [16:0] st_len_rd;
  logic [17:0] st_rate_rd;
  logic        st_def_rd;

  assign st_idx      = (op_r == OP_TICK || op_r == OP_SET_RATE) ? vsmp_r[vidx_r] : sid_r;
  assign st_start_rd = st_start_r[st_idx];
  assign st_len_rd   = st_len_r[st_idx];
  assign st_rate_rd  = st_rate_r[st_idx];
  assign st_def_rd   = st_def_r[st_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_def_r <= '0;
    end else if (cmd.step == DP_DEFINE) begin
      st_def_r[sid_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == DP_DEFINE) begin
      st_start_r[sid_r] <= start_r;
      st_len_r[sid_r]   <= len_r;
      st_rate_r[sid_r]  <= srate_r;
    end
  end

  // lowest free voice
  logic [VB-1:0] free_idx;
  logic          free_any;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!vact_r[i]) begin
        free_idx = VB'(i);
        free_any = 1'b1;
      end
    end
  end

  // handle match, checked against the selected voice
  logic [SLOT_BITS-1:0] hslot;
  logic                 hnd_ok;

  assign hslot  = handle_r[SLOT_BITS-1:0];
  assign hnd_ok = !handle_r[31] && (32'(hslot) < 32'(VOICES)) && vact_r[vidx_r] &&
                  (vgen_r[vidx_r] == handle_r[30:SLOT_BITS]);

  // increment divider: floor(rate * srate * 256 / orate)
  logic [41:0] dvd_r;
  logic [17:0] rem_r;
  logic [5:0]  dcnt_r;
  logic        nz_r;
  logic [33:0] mprod;
  logic [18:0] trial;
  logic        ge;
  logic [31:0] inc_q;

  assign mprod = 34'(rate_r) * 34'(st_rate_rd);
  assign trial = {rem_r, dvd_r[41]};
  assign ge    = trial >= {1'b0, orate_r};

  always_ff @(posedge clk) begin
    case (cmd.step)
      DP_MUL: begin
        dvd_r  <= {mprod, 8'd0};
        nz_r   <= (mprod != '0);
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      DP_DIV: begin
        rem_r  <= ge ? 18'(trial - {1'b0, orate_r}) : trial[17:0];
        dvd_r  <= {dvd_r[40:0], ge};
        dcnt_r <= dcnt_r + 6'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (orate_r == '0)      inc_q = nz_r ? '1 : '0;
    else if (|dvd_r[41:32]) inc_q = '1;
    else                    inc_q = dvd_r[31:0];
  end

  // per-voice tick path
  logic [23:0]    pos_int;
  logic           v_end;
  logic [15:0]    step_v;
  logic [16:0]    ramp_p1;
  logic [15:0]    tgt_v, now_v, new_now;
  logic [SW-1:0]  addr_a, addr_b;
  logic [AW-1:0]  rd_addr, wr_addr;

  assign pos_int = vpos_r[vidx_r][39:16];
  assign v_end   = (st_len_rd < 17'd2) ||
                   ({1'b0, pos_int} >= (25'(st_len_rd) - 25'd1));
  assign ramp_p1 = {1'b0, ramp_r} + 17'd1;
  assign step_v  = ramp_p1[16:1];
  assign tgt_v   = vstop_r[vidx_r] ? 16'd0 : vtgt_r[vidx_r];
  assign now_v   = vnow_r[vidx_r];

  always_comb begin
    if (tgt_v > now_v) new_now = ((tgt_v - now_v) > step_v) ? now_v + step_v : tgt_v;
    else               new_now = ((now_v - tgt_v) > step_v) ? now_v - step_v : tgt_v;
  end

  assign addr_a  = SW'(st_start_rd) + SW'(pos_int);
  assign addr_b  = addr_a + SW'(1);
  assign rd_addr = (cmd.step == DP_V_RDA) ? addr_b[AW-1:0] : addr_a[AW-1:0];
  assign wr_addr = AW'(SW'(waddr_r));

  // sample memory
  logic [15:0] mem [SAMPLE_WORDS];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.step == DP_LOAD) mem[wr_addr] <= wval_r;
    rdata_r <= mem[rd_addr];
  end

  logic signed [15:0] a_r;
  logic signed [16:0] diff, frac_s, now_s;
  logic signed [33:0] p1_r, p2_r;
  logic signed [17:0] frame;
  logic signed [23:0] sum_r;

  assign diff   = $signed({rdata_r[15], rdata_r}) - $signed({a_r[15], a_r});
  assign frac_s = $signed({1'b0, vpos_r[vidx_r][15:0]});
  assign frame  = $signed({{2{a_r[15]}}, a_r}) + $signed(p1_r[33:16]);
  assign now_s  = $signed({1'b0, now_v});

  always_ff @(posedge clk) begin
    case (cmd.step)
      DP_TICK_INIT: sum_r <= '0;
      DP_V_RDA:     a_r   <= $signed(rdata_r);
      DP_V_RDB:     p1_r  <= 34'(diff) * 34'(frac_s);
      DP_V_FRM:     p2_r  <= 34'(frame) * 34'(now_s);
      DP_V_ACC:     sum_r <= sum_r + $signed({{4{p2_r[33]}}, p2_r[33:14]});
      default: ;
    endcase
  end

  // voice control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vact_r <= '0;
      vidx_r <= '0;
      for (int i = 0; i < VOICES; i++) vgen_r[i] <= '0;
    end else begin
      case (cmd.step)
        DP_PLAY_SEL:  vidx_r <= free_idx;
        DP_HND_SEL:   vidx_r <= VB'(hslot);
        DP_TICK_INIT: vidx_r <= '0;
        DP_V_NEXT:    vidx_r <= vidx_r + VB'(1);
        DP_SILENCE:   vact_r <= '0;
        DP_PLAY_WR: begin
          vact_r[vidx_r] <= 1'b1;
          vgen_r[vidx_r] <= vgen_r[vidx_r] + GEN_W'(1);
        end
        DP_V_CHK: if (vact_r[vidx_r] && v_end) vact_r[vidx_r] <= 1'b0;
        DP_V_ACC: if (vstop_r[vidx_r] && now_v <= FADE_FLOOR) vact_r[vidx_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // voice payload state
  always_ff @(posedge clk) begin
    case (cmd.step)
      DP_PLAY_WR: begin
        vsmp_r[vidx_r]  <= sid_r;
        vpos_r[vidx_r]  <= '0;
        vnow_r[vidx_r]  <= '0;
        vtgt_r[vidx_r]  <= vol_r;
        vstop_r[vidx_r] <= 1'b0;
        vinc_r[vidx_r]  <= inc_q;
      end
      DP_RATE_WR: vinc_r[vidx_r]  <= inc_q;
      DP_VOL_WR:  vtgt_r[vidx_r]  <= vol_r;
      DP_STOP_WR: vstop_r[vidx_r] <= 1'b1;
      DP_V_CHK:   if (vact_r[vidx_r] && !v_end) vnow_r[vidx_r] <= new_now;
      DP_V_ACC:   vpos_r[vidx_r] <= vpos_r[vidx_r] + 40'(vinc_r[vidx_r]);
      default: ;
    endcase
  end

  // result register
  logic [OUT_W-1:0] out_r;
  logic [15:0]      mix;
  logic             clip;
  logic [31:0]      hout;

  always_comb begin
    mix  = '0;
    clip = 1'b0;
    if (op_r == OP_TICK) begin
      if (sum_r > 24'sd32767) begin
        mix  = 16'h7fff;
        clip = 1'b1;
      end else if (sum_r < -24'sd32768) begin
        mix  = 16'h8000;
        clip = 1'b1;
      end else begin
        mix = sum_r[15:0];
      end
    end
    hout = (op_r == OP_PLAY && !cmd.fail) ?
           {1'b0, vgen_r[vidx_r], SLOT_BITS'(vidx_r)} : '1;
  end

  always_ff @(posedge clk) begin
    if (cmd.step == DP_RESULT) out_r <= {6'd0, clip, mix, mix, hout, cmd.fail};
  end

  assign out_tdata = out_r;

  assign stat.op         = op_r;
  assign stat.def_ok     = (len_r >= 17'd2) && (srate_r != '0) && !st_def_rd;
  assign stat.play_ok    = st_def_rd && free_any;
  assign stat.hnd_ok     = hnd_ok;
  assign stat.v_live     = vact_r[vidx_r] && !v_end;
  assign stat.div_last   = (dcnt_r == 6'(DIV_STEPS - 1));
  assign stat.last_voice = (vidx_r == VB'(VOICES - 1));

endmodule

// ===== sv/sample_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// sample_voice_mixer: multi-voice sample playback mixer
// Sequencer plus datapath; one item in flight, result held in an output reg.
// ----------------------------------------------------------------------------
// Load/define/silence pass through decode and done; play and set-rate add
//   one 16x18 multiply, then a 42-step restoring divider for the increment.
// Tick: every voice is checked; a sounding voice is read, interpolated, scaled
//   and accumulated (one sample memory read port, two reads per voice).
// One item at a time; the next transfer is taken while a result waits.
// Reset (rst_n low, synchronous): voices released, generations zeroed, sample
//   table emptied, ramp_step 137, output_rate_hz 48000. Sample memory is kept.
module sample_voice_mixer #(
  parameter int VOICES       = svm_pkg::DEF_VOICES,
  parameter int SAMPLE_WORDS = svm_pkg::DEF_SAMPLE_WORDS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // op[2:0] sample_id[6:3] voice_handle[38:7] volume[54:39] rate[70:55]
  // word_address[86:71] word_value[102:87] start_address[118:103]
  // sample_length[135:119] sample_rate_hz[153:136]
  input  logic [svm_pkg::IN_W-1:0]       in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // status[0] handle_out[32:1] left_sample[48:33] right_sample[64:49] clipped[65]
  output logic [svm_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [svm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import svm_pkg::*;

  dp_cmd_t  cmd;   // sequencer -> datapath step
  dp_stat_t stat;  // datapath decisions back

  svm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  svm_dp #(
    .VOICES       (VOICES),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

// ===== sv/svm_chk.sv =====
// ----------------------------------------------------------------------------
// svm_chk: port-level checks
// Watches the result channel of the mixer over time.
// ----------------------------------------------------------------------------
module svm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic [71:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_stereo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[48:33] == out_tdata[64:49])
    else $error("left and right differ");

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |->
      out_tdata[48:33] == 16'h7fff || out_tdata[48:33] == 16'h8000)
    else $error("clip flag without saturated mix");

  a_fail_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[32:1] == 32'hffffffff)
    else $error("rejected item returned a handle");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sample_voice_mixer svm_chk u_svm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
